/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the neighbor advertisement parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/nalap_pkg.sv */
// Package for the neighbor advertisement link-layer address parser.
// Holds result codes, register indexes and fixed field widths; no dependencies.
package nalap_pkg;

    localparam int HDR_BYTES   = 24;
    localparam int NA_TYPE     = 136;
    localparam int OPT_TLLA    = 2;
    localparam int LINK_ADDR_W = 48;
    localparam int ADDR_LEN_W  = 11;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 8'd1;

    typedef enum logic [1:0] {
        STATUS_FOUND      = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_NO_OPTION  = 2'd2
    } status_t;

endpackage

/* hw/rtl/neighbor_advert_link_addr_parser.sv */
// A byte is registered in the input register on acceptance and its result, if the byte ends
// the packet, is then registered in the result register once that register is empty or being read.
// Throughput: one byte per cycle, except while a packet's last byte waits on a full result register;
// the per-byte header check and option walk fit in one stage between the input register and the
// result register. Reset: asynchronous, active low; clears the walk state, the target address and both valids.
// Depends on nalap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module neighbor_advert_link_addr_parser
    import nalap_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int ADDR_BYTES       = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_packet
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [47:0] link_addr, [58:48] addr_len, rest zero
    output logic [1:0]            m_tuser    // [1:0] status
);

    localparam int OFF_W  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int SUM_W  = ((OFF_W > 11) ? OFF_W : 11) + 1;
    localparam int KW     = $clog2(ADDR_BYTES);
    localparam int CAP_W  = ADDR_BYTES * 8;

    // configuration
    logic [63:0] target_high_reg, target_high_next;
    logic [63:0] target_low_reg, target_low_next;

    // input stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_data_reg;
    logic                 s1_last_reg;
    logic                 s1_adv;

    // walk state
    logic [OFF_W-1:0]     byte_offset_reg, byte_offset_next;
    logic                 header_match_reg, header_match_next;
    logic [OFF_W-1:0]     next_opt_reg, next_opt_next;
    logic                 walk_stopped_reg, walk_stopped_next;
    logic                 option_found_reg, option_found_next;
    logic [OFF_W-1:0]     opt_end_reg, opt_end_next;
    logic [ADDR_BYTES-1:0][7:0] captured_reg, captured_next;
    logic [7:0]           opt_type_reg, opt_type_next;

    // result stage
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [1:0]           out_user_reg;
    logic [M_TDATA_W-1:0] res_data;
    status_t              res_status;

    // per-byte working values
    logic [OFF_W-1:0]     u_offset;
    logic                 u_match;
    logic [OFF_W-1:0]     u_next_opt;
    logic                 u_stopped;
    logic                 u_found;
    logic [OFF_W-1:0]     u_end;
    logic [ADDR_BYTES-1:0][7:0] u_captured;
    logic [7:0]           u_type;

    logic [15:0][7:0]     tgt_bytes;
    logic [3:0]           tgt_idx;
    logic [SUM_W-1:0]     o_ext;
    logic [SUM_W-1:0]     first_ext;
    logic [SUM_W-1:0]     k_ext;
    logic [SUM_W-1:0]     len_ext;
    logic [SUM_W-1:0]     end_ext;
    logic [SUM_W-1:0]     alen_ext;
    logic [KW-1:0]        slot;
    logic [CAP_W-1:0]     cap_flat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    assign tgt_bytes = {target_high_reg, target_low_reg};
    assign tgt_idx   = 4'd15 - {byte_offset_reg[4], byte_offset_reg[2:0]};
    assign o_ext     = SUM_W'(byte_offset_reg);
    assign first_ext = SUM_W'(next_opt_reg) + SUM_W'(2);
    assign k_ext     = o_ext - first_ext;
    assign slot      = KW'(ADDR_BYTES - 1) - k_ext[KW-1:0];
    assign len_ext   = SUM_W'({s1_data_reg, 3'b000});
    assign end_ext   = SUM_W'(next_opt_reg) + len_ext;

    always_comb
    begin
        target_high_next = target_high_reg;
        target_low_next  = target_low_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TARGET_HIGH)
            begin
                target_high_next = cfg_data;
            end
            else if (cfg_index == REG_TARGET_LOW)
            begin
                target_low_next = cfg_data;
            end
        end
    end

    // process the registered byte
    always_comb
    begin
        u_offset   = byte_offset_reg;
        u_match    = header_match_reg;
        u_next_opt = next_opt_reg;
        u_stopped  = walk_stopped_reg;
        u_found    = option_found_reg;
        u_end      = opt_end_reg;
        u_captured = captured_reg;
        u_type     = opt_type_reg;

        if (byte_offset_reg >= OFF_W'(MAX_PACKET_BYTES))
        begin
            u_match = 1'b0;
        end
        else
        begin
            u_offset = byte_offset_reg + OFF_W'(1);
            if (o_ext == SUM_W'(0) && s1_data_reg != 8'(NA_TYPE))
            begin
                u_match = 1'b0;
            end
            if (o_ext == SUM_W'(1) && s1_data_reg != 8'd0)
            begin
                u_match = 1'b0;
            end
            if (o_ext >= SUM_W'(8) && o_ext < SUM_W'(HDR_BYTES) &&
                tgt_bytes[tgt_idx] != s1_data_reg)
            begin
                u_match = 1'b0;
            end

            if (option_found_reg)
            begin
                if (o_ext >= first_ext && o_ext < SUM_W'(opt_end_reg) &&
                    k_ext < SUM_W'(ADDR_BYTES))
                begin
                    u_captured[slot] = captured_reg[slot] | s1_data_reg;
                end
            end
            else if (!walk_stopped_reg)
            begin
                if (o_ext == SUM_W'(next_opt_reg))
                begin
                    u_type = s1_data_reg;
                end
                else if (o_ext == SUM_W'(next_opt_reg) + SUM_W'(1))
                begin
                    if (len_ext == SUM_W'(0) || end_ext > SUM_W'(MAX_PACKET_BYTES))
                    begin
                        u_stopped = 1'b1;
                    end
                    else if (opt_type_reg == 8'(OPT_TLLA))
                    begin
                        u_found = 1'b1;
                        u_end   = OFF_W'(end_ext);
                    end
                    else
                    begin
                        u_next_opt = OFF_W'(end_ext);
                    end
                end
            end
        end

        cap_flat = u_captured;
        alen_ext = SUM_W'(u_end) - SUM_W'(u_next_opt) - SUM_W'(2);
        res_data = '0;
        if (!u_match || u_offset < OFF_W'(HDR_BYTES))
        begin
            res_status = STATUS_BAD_HEADER;
        end
        else if (u_found && u_end <= u_offset)
        begin
            res_status = STATUS_FOUND;
            res_data   = {5'b0, alen_ext[ADDR_LEN_W-1:0], cap_flat[LINK_ADDR_W-1:0]};
        end
        else
        begin
            res_status = STATUS_NO_OPTION;
        end
    end

    always_comb
    begin
        s1_valid_next     = s1_valid_reg;
        byte_offset_next  = byte_offset_reg;
        header_match_next = header_match_reg;
        next_opt_next     = next_opt_reg;
        walk_stopped_next = walk_stopped_reg;
        option_found_next = option_found_reg;
        opt_end_next      = opt_end_reg;
        captured_next     = captured_reg;
        opt_type_next     = opt_type_reg;
        out_valid_next    = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_last_reg)
            begin
                out_valid_next    = 1'b1;
                byte_offset_next  = '0;
                header_match_next = 1'b1;
                next_opt_next     = OFF_W'(HDR_BYTES);
                walk_stopped_next = 1'b0;
                option_found_next = 1'b0;
                opt_end_next      = '0;
                captured_next     = '0;
                opt_type_next     = '0;
            end
            else
            begin
                byte_offset_next  = u_offset;
                header_match_next = u_match;
                next_opt_next     = u_next_opt;
                walk_stopped_next = u_stopped;
                option_found_next = u_found;
                opt_end_next      = u_end;
                captured_next     = u_captured;
                opt_type_next     = u_type;
            end
        end
        if (s_tvalid && s_tready)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_high_reg  <= '0;
            target_low_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            byte_offset_reg  <= '0;
            header_match_reg <= 1'b1;
            next_opt_reg     <= OFF_W'(HDR_BYTES);
            walk_stopped_reg <= 1'b0;
            option_found_reg <= 1'b0;
            opt_end_reg      <= '0;
            captured_reg     <= '0;
            opt_type_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            target_high_reg  <= target_high_next;
            target_low_reg   <= target_low_next;
            s1_valid_reg     <= s1_valid_next;
            byte_offset_reg  <= byte_offset_next;
            header_match_reg <= header_match_next;
            next_opt_reg     <= next_opt_next;
            walk_stopped_reg <= walk_stopped_next;
            option_found_reg <= option_found_next;
            opt_end_reg      <= opt_end_next;
            captured_reg     <= captured_next;
            opt_type_reg     <= opt_type_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // hold payloads
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_data_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_status;
        end
    end

    `ASSERT_ALWAYS(a_offset_range, byte_offset_reg <= OFF_W'(MAX_PACKET_BYTES), "offset range")
    `ASSERT_ALWAYS(a_found_xor_stop, !(option_found_reg && walk_stopped_reg), "found and stopped")
    `ASSERT_IMPLY(a_miss_zero, m_tvalid && m_tuser != STATUS_FOUND, m_tdata == '0, "miss payload")
    `ASSERT_IMPLY(a_result_src, $rose(out_valid_reg), $past(s1_adv && s1_last_reg), "no last")

endmodule
